@@ src/rpld_pkg.sv @@
// Shared types, register indexes and the step compare function of the loop detector.
package rpld_pkg;

   localparam int MASK_W = 4;
   localparam int MOVE_W = 2;
   localparam int MS_W = 16;
   localparam int LEN_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int COUNT_OUT_W = 5;
   // longest pattern length a LEN_W-bit register can name
   localparam int LEN_LIMIT = (1 << LEN_W) - 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TIME_TOL = 2'd0,
      CSR_MIN_LEN  = 2'd1,
      CSR_MAX_LEN  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [MASK_W-1:0] mask;
      logic [MOVE_W-1:0] move;
      logic [MS_W-1:0]   ms;
   } rec_type;

   typedef struct packed {
      logic [MS_W-1:0]  time_tol;
      logic [LEN_W-1:0] min_len;
      logic [LEN_W-1:0] max_len;
   } cfg_type;

   function automatic logic same_step(rec_type a, rec_type b, logic [MS_W-1:0] tol);
      logic [MS_W-1:0] diff;
      diff = (a.ms > b.ms) ? (a.ms - b.ms) : (b.ms - a.ms);
      return (a.mask == b.mask) && (a.move == b.move) && (diff <= tol);
   endfunction

endpackage

@@ src/rpld_cell.sv @@
// One history cell: holds a step record and passes it to the next cell on each beat.
module rpld_cell
   import rpld_pkg::*;
(
   input  logic    clock,
   input  logic    shift_en,
   input  rec_type rec_in,
   output rec_type rec_out
);

   rec_type rec_ff;
   rec_type rec_in_w;

   always_comb begin
      rec_in_w = shift_en ? rec_in : rec_ff;
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in_w;
   end

   assign rec_out = rec_ff;

endmodule

@@ src/rpld_match.sv @@
// Pattern matcher: compares the newest records against the ones before them for each length.
module rpld_match
   import rpld_pkg::*;
#(
   parameter int LEN_TOP = 4,
   parameter int CW      = 5
)(
   input  rec_type          recs [2*LEN_TOP],
   input  logic [CW-1:0]    count,
   input  cfg_type          cfg,
   output logic             loop_hit
);

   logic [LEN_W-1:0] lo;
   logic [LEN_W-1:0] hi;
   logic [LEN_TOP:1] len_ok;

   always_comb begin
      lo = (cfg.min_len == '0) ? LEN_W'(1) : cfg.min_len;
      hi = (cfg.max_len > LEN_W'(LEN_TOP)) ? LEN_W'(LEN_TOP) : cfg.max_len;
   end

   always_comb begin
      for (int l = 1; l <= LEN_TOP; l++) begin
         len_ok[l] = (LEN_W'(l) >= lo) && (LEN_W'(l) <= hi) &&
                     (8'(count) >= 8'(2 * l));
         for (int d = 0; d < l; d++) begin
            len_ok[l] = len_ok[l] && same_step(recs[d], recs[d+l], cfg.time_tol);
         end
      end
      loop_hit = |len_ok;
   end

endmodule

@@ src/repeated_path_loop_detector_core.sv @@
// Top level of the repeated path loop detector.
//
// Usage: each req_ beat carries one step record (junction mask, move, travel
// time). It is appended to a history of HISTORY_DEPTH records; one rsp_ beat
// follows per req_ beat, giving rsp_loop_found (the newest len records match
// the len before them for some len in min_len..max_len) and rsp_history_count.
// The newest records sit in a chain of 2*min(MAX_PATTERN_LEN,7) cells that
// shift by one on every accepted beat; the matcher compares them in parallel.
// The accepting edge shifts the chain and marks a result pending; the result is
// registered, raising rsp_valid, when the output register is empty or rsp_ready.
// Throughput: one beat per cycle while rsp_ready is high.
// When the receiver stalls, the result stays in the output register, one more
// beat is taken and held in the chain, then req_ready drops until rsp_ready.
// Reset empties the history (count zero), drops pending results and restores
// time_tolerance 100, min_len 2, max_len 4. csr_ writes take effect at once
// and must be made only while the block is idle; the block does not enforce it.
module repeated_path_loop_detector_core
   import rpld_pkg::*;
#(
   parameter int HISTORY_DEPTH   = 16,
   parameter int MAX_PATTERN_LEN = 4
)(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [MASK_W-1:0]      req_node_mask,
   input  logic [MOVE_W-1:0]      req_move,
   input  logic [MS_W-1:0]        req_travel_ms,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_loop_found,
   output logic [COUNT_OUT_W-1:0] rsp_history_count,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int LEN_TOP = (MAX_PATTERN_LEN < LEN_LIMIT) ? MAX_PATTERN_LEN : LEN_LIMIT;
   localparam int CELLS = 2 * LEN_TOP;
   localparam int CW = $clog2(HISTORY_DEPTH + 1);

   cfg_type cfg_ff, cfg_in;
   logic [CW-1:0] count_ff, count_in;
   logic calc_ff, calc_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_loop_found_ff;
   logic [COUNT_OUT_W-1:0] rsp_history_count_ff;

   logic acc;
   logic out_load;
   logic loop_hit;
   rec_type new_rec;
   rec_type chain_in [CELLS];
   rec_type recs [CELLS];

   // config registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_TIME_TOL: cfg_in.time_tol = csr_wdata;
            CSR_MIN_LEN:  cfg_in.min_len = csr_wdata[LEN_W-1:0];
            CSR_MAX_LEN:  cfg_in.max_len = csr_wdata[LEN_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      out_load = calc_ff && (!rsp_valid_ff || rsp_ready);
      req_ready = !calc_ff || out_load;
      acc = req_valid && req_ready;
      calc_in = acc || (calc_ff && !out_load);
      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);
      count_in = count_ff;
      if (acc && (count_ff != CW'(HISTORY_DEPTH))) begin
         count_in = count_ff + CW'(1);
      end
      new_rec.mask = req_node_mask;
      new_rec.move = req_move;
      new_rec.ms = req_travel_ms;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.time_tol <= CSR_DATA_W'(100);
         cfg_ff.min_len <= LEN_W'(2);
         cfg_ff.max_len <= LEN_W'(4);
         count_ff <= '0;
         calc_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         count_ff <= count_in;
         calc_ff <= calc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_loop_found_ff <= loop_hit;
         rsp_history_count_ff <= COUNT_OUT_W'(count_ff);
      end
   end

   // record chain, newest in cell 0
   genvar k;
   generate
      for (k = 0; k < CELLS; k++) begin : g_cell
         if (k == 0) begin : g_head
            assign chain_in[k] = new_rec;
         end else begin : g_link
            assign chain_in[k] = recs[k-1];
         end
         rpld_cell u_cell (
            .clock    (clock),
            .shift_en (acc),
            .rec_in   (chain_in[k]),
            .rec_out  (recs[k])
         );
      end
   endgenerate

   rpld_match #(
      .LEN_TOP (LEN_TOP),
      .CW      (CW)
   ) u_match (
      .recs     (recs),
      .count    (count_ff),
      .cfg      (cfg_ff),
      .loop_hit (loop_hit)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_loop_found = rsp_loop_found_ff;
   assign rsp_history_count = rsp_history_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(HISTORY_DEPTH))
      else $error("record count above history depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (acc && (count_ff != CW'(HISTORY_DEPTH))) |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("record count did not advance on beat");

   a_calc_after_acc: assert property (@(posedge clock) disable iff (reset)
      acc |=> calc_ff)
      else $error("accepted beat left no pending result");

   a_hit_needs_history: assert property (@(posedge clock) disable iff (reset)
      (out_load && loop_hit) |-> (count_ff >= CW'(2)))
      else $error("loop reported with fewer than two records");

endmodule
